/* src/lkv_pkg.sv */
package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CFG_W   = 5;

  localparam logic [CFG_W-1:0] CAPACITY_RESET = CFG_W'(16);

  // Word index of the configuration registers.
  typedef enum logic [0:0] {
    REG_CAPACITY = 1'b0
  } reg_idx_e;

  typedef enum logic [0:0] {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } action_e;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    action_e            action;
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   write_value;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [VAL_W-1:0]   read_value;
    logic               evicted;
  } rsp_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic idx_t first_set(input logic [ENTRIES-1:0] vec);
    idx_t idx;
    idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

/* src/lkv_store.sv */
module lkv_store (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  lkv_pkg::req_t req_i,
  input  lkv_pkg::cnt_t cap_i,
  output lkv_pkg::rsp_t rsp_o
);
  import lkv_pkg::*;

  logic [KEY_W-1:0]   keys_q   [ENTRIES];
  logic [VAL_W-1:0]   values_q [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  idx_t               rank_q   [ENTRIES];
  cnt_t               occ_q;

  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] evict_vec;
  logic               hit;
  idx_t               hit_idx;
  idx_t               hit_rank;
  logic [VAL_W-1:0]   hit_val;
  logic               full;
  cnt_t               occ_m1;
  idx_t               oldest;
  idx_t               ins_slot;
  logic               is_put;

  always_comb begin
    hit_val = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_q[i] && (keys_q[i] == req_i.key);
      if (hit_vec[i]) begin
        hit_val = hit_val | values_q[i];
      end
    end
  end

  assign hit      = |hit_vec;
  assign hit_idx  = first_set(hit_vec);
  assign hit_rank = rank_q[hit_idx];
  assign is_put   = (req_i.action == ACT_PUT);

  // Capacity is at least one, so a full store always has a valid oldest entry.
  assign full   = (occ_q >= cap_i);
  assign occ_m1 = occ_q - CNT_W'(1);
  assign oldest = occ_m1[IDX_W-1:0];

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      evict_vec[i] = valid_q[i] && (rank_q[i] == oldest);
    end
  end

  assign ins_slot = full ? first_set(evict_vec) : first_set(~valid_q);

  always_comb begin
    rsp_o.found      = hit;
    rsp_o.evicted    = is_put && !hit && full;
    if (is_put) begin
      rsp_o.read_value = '0;
    end else if (hit) begin
      rsp_o.read_value = hit_val;
    end else begin
      rsp_o.read_value = '1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (en_i) begin
      if (hit) begin
        // Entries younger than the hit age by one; the hit becomes most recent.
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_q[i] && (rank_q[i] < hit_rank)) begin
            rank_q[i] <= rank_q[i] + IDX_W'(1);
          end
        end
        rank_q[hit_idx] <= '0;
      end else if (is_put) begin
        // The evicted entry is reused in place, so every other valid entry ages.
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_q[i] && (IDX_W'(i) != ins_slot)) begin
            rank_q[i] <= rank_q[i] + IDX_W'(1);
          end
        end
        rank_q[ins_slot]  <= '0;
        valid_q[ins_slot] <= 1'b1;
        if (!full) begin
          occ_q <= occ_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && is_put) begin
      if (hit) begin
        values_q[hit_idx] <= req_i.write_value;
      end else begin
        keys_q[ins_slot]   <= req_i.key;
        values_q[ins_slot] <= req_i.write_value;
      end
    end
  end

endmodule

/* src/lru_key_value_cache.sv */
// Dataflow: each item is accepted into the input register and its result is written to
// the result register when that register is free, so an output stall holds it back.
// Throughput: 1 item per cycle while the output is not stalled; all key compares and
// recency updates of the 16 entries are done between the input and result registers.
// Reset: asynchronous, active low; clears all entries, the fill count and the
// recency ranks, and sets capacity to 16. No clearing pass is needed.
module lru_key_value_cache (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] key, [63:32] write_value
  input  logic        s_axis_tuser,   // [0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] read_value
  output logic [1:0]  m_axis_tuser,   // [0] found, [1] evicted
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lkv_pkg::*;

  logic             cap_we;
  logic [CFG_W-1:0] cap_q;
  cnt_t             cap_eff;

  logic             in_valid_q;
  req_t             in_req_q;
  logic             out_valid_q;
  rsp_t             out_rsp_q;
  rsp_t             rsp;
  logic             out_free;
  logic             advance;
  logic             s_acc;

  // Configuration port.
  assign pready = 1'b1;
  assign cap_we = psel && penable && pwrite && (reg_idx_e'(paddr[2]) == REG_CAPACITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAPACITY_RESET;
    end else if (cap_we) begin
      cap_q <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (reg_idx_e'(paddr[2]) == REG_CAPACITY) begin
      prdata = 32'(cap_q);
    end else begin
      prdata = '0;
    end
  end

  // Zero capacity behaves as one; anything above the entry count saturates.
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(cap_q) > ENTRIES) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(cap_q);
    end
  end

  // Handshake: the input register drains whenever the result register is free.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_acc) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_req_q.action      <= action_e'(s_axis_tuser);
      in_req_q.key         <= s_axis_tdata[31:0];
      in_req_q.write_value <= s_axis_tdata[63:32];
    end
    if (advance) begin
      out_rsp_q <= rsp;
    end
  end

  lkv_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .req_i  (in_req_q),
    .cap_i  (cap_eff),
    .rsp_o  (rsp)
  );

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_rsp_q.read_value;
  assign m_axis_tuser[0] = out_rsp_q.found;
  assign m_axis_tuser[1] = out_rsp_q.evicted;

endmodule

/* tb/testbench.sv */
module testbench;
  import lkv_pkg::*;

  localparam int WATCHDOG_LIMIT   = 3000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int POOL_SIZE        = 40;
  localparam int PHASES           = 10;
  localparam int PHASE_ITEMS      = 115;
  localparam int MAX_REPORTS      = 10;

  localparam logic [2:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
  // Word index one past the register list; writes there must be ignored.
  localparam logic [2:0] UNMAPPED_ADDR = 3'd4;

  // Golden copy of the cache: slot contents, recency ages and the capacity register.
  class lru_scoreboard;
    logic [KEY_W-1:0] slot_key[ENTRIES];
    logic [VAL_W-1:0] slot_value[ENTRIES];
    bit               slot_valid[ENTRIES];
    int unsigned      slot_age[ENTRIES];
    int unsigned      occupancy;
    logic [CFG_W-1:0] capacity;
    rsp_t             expected_q[$];
    int               mismatches;

    function void clear();
      for (int i = 0; i < ENTRIES; i++) begin
        slot_key[i]   = '0;
        slot_value[i] = '0;
        slot_valid[i] = 1'b0;
        slot_age[i]   = 0;
      end
      occupancy  = 0;
      capacity   = CAPACITY_RESET;
      mismatches = 0;
      expected_q.delete();
    endfunction

    function void write_reg(logic [2:0] addr, logic [31:0] data);
      if (addr == CAPACITY_ADDR) begin
        capacity = data[CFG_W-1:0];
      end
    endfunction

    // Every valid slot younger than s ages by one, then s becomes the newest.
    function void make_recent(int s);
      int unsigned old_age;
      old_age = slot_age[s];
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_valid[i] && slot_age[i] < old_age) begin
          slot_age[i]++;
        end
      end
      slot_age[s] = 0;
    endfunction

    function void note_request(action_e act, logic [KEY_W-1:0] key,
                               logic [VAL_W-1:0] wval);
      int unsigned limit;
      int          hit;
      int          slot;
      rsp_t        rsp;
      limit = capacity;
      if (limit == 0) begin
        limit = 1;
      end
      if (limit > ENTRIES) begin
        limit = ENTRIES;
      end
      hit = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit < 0 && slot_valid[i] && slot_key[i] == key) begin
          hit = i;
        end
      end
      rsp = '0;
      if (act == ACT_GET) begin
        if (hit >= 0) begin
          rsp.found      = 1'b1;
          rsp.read_value = slot_value[hit];
          make_recent(hit);
        end else begin
          rsp.read_value = '1;
        end
      end else if (hit >= 0) begin
        rsp.found       = 1'b1;
        slot_value[hit] = wval;
        make_recent(hit);
      end else begin
        slot = -1;
        // A full store drops exactly one entry, the oldest, even when
        // occupancy is above a capacity that was lowered later.
        if (occupancy >= limit && occupancy > 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && slot_valid[i] && slot_age[i] == occupancy - 1) begin
              slot = i;
            end
          end
          if (slot >= 0) begin
            slot_valid[slot] = 1'b0;
            occupancy--;
            rsp.evicted = 1'b1;
          end
        end
        if (slot < 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && !slot_valid[i]) begin
              slot = i;
            end
          end
        end
        if (slot >= 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i]) begin
              slot_age[i]++;
            end
          end
          slot_valid[slot] = 1'b1;
          slot_key[slot]   = key;
          slot_value[slot] = wval;
          slot_age[slot]   = 0;
          occupancy++;
        end
      end
      expected_q.push_back(rsp);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("ERROR: unexpected result found=%0b read_value=%h evicted=%0b",
                   got.found, got.read_value, got.evicted);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.found !== want.found || got.read_value !== want.read_value ||
          got.evicted !== want.evicted) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("ERROR: result mismatch at %0t: expected found=%0b read_value=%h evicted=%0b, got found=%0b read_value=%h evicted=%0b",
                   $realtime, want.found, want.read_value, want.evicted,
                   got.found, got.read_value, got.evicted);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lru_scoreboard    sb = new();
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  bit               tx_idle_on;
  bit               rx_idle_on;
  bit               long_hold_req;
  rsp_t             observed;
  int               idle_cycles;

  lru_key_value_cache u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Both handshakes are sampled on the edge, before any flop of this edge updates.
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sb.note_request(action_e'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[63:32]);
    end
    if (m_axis_tvalid && m_axis_tready) begin
      observed.found      = m_axis_tuser[0];
      observed.read_value = m_axis_tdata;
      observed.evicted    = m_axis_tuser[1];
      sb.check_response(observed);
    end
  end

  // Result side: random stalls, plus one long hold on request from the stimulus.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAIL lru_key_value_cache");
    $finish;
  end

  task automatic send_request(action_e act, logic [KEY_W-1:0] key, logic [VAL_W-1:0] wval);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {wval, key};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
  endtask

  task automatic maybe_gap();
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(addr, data);
  endtask

  // Mostly keys from a pool a little larger than the capacity, so hits,
  // updates and evictions all happen often.
  function automatic logic [KEY_W-1:0] pick_key(int unsigned pool_n);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return key_pool[$urandom_range(0, pool_n - 1)];
    end else if (r < 80) begin
      case ($urandom_range(0, 3))
        0:       return 32'h0000_0000;
        1:       return 32'hFFFF_FFFF;
        2:       return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return $urandom();
  endfunction

  initial begin
    logic [CFG_W-1:0] caps[PHASES];
    int unsigned      eff_cap;
    int unsigned      pool_n;
    caps = '{5'd1, 5'd16, 5'd3, 5'd0, 5'd31, 5'd8, 5'd17, 5'd2, 5'd12, 5'd16};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_GET;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    tx_idle_on    = 1'b0;
    rx_idle_on    = 1'b0;
    long_hold_req = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom();
    end
    sb.clear();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset capacity: empty miss, extreme keys and
    // values, hits, an update, a miss, a full store and one eviction.
    send_request(ACT_GET, 32'h0000_0000, 32'hDEAD_BEEF);
    send_request(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(ACT_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_GET, 32'h8000_0000, 32'h0000_0000);
    send_request(ACT_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(ACT_PUT, 32'h8000_0000, 32'h1234_5678);
    send_request(ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(ACT_GET, 32'h5555_AAAA, 32'h0000_0000);
    for (int k = 1; k <= 12; k++) begin
      send_request(ACT_PUT, 32'(k), ~32'(k));
    end
    send_request(ACT_PUT, 32'hAAAA_5555, 32'h0F0F_F0F0);
    wait_drain();
    write_register(UNMAPPED_ADDR, 32'h0000_0001);

    // The store is full when the first phase drops the capacity to one.
    for (int p = 0; p < PHASES; p++) begin
      wait_drain();
      write_register(CAPACITY_ADDR, {27'($urandom()), caps[p]});
      eff_cap = (caps[p] == 0) ? 1 : (caps[p] > ENTRIES) ? ENTRIES : caps[p];
      pool_n  = eff_cap + $urandom_range(2, 6);
      tx_idle_on = (p % 3 != 2) && (p != PHASES - 1);
      rx_idle_on = tx_idle_on;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 40) begin
          long_hold_req = 1'b1;
        end
        if (p == 5 && n == 60) begin
          wait_drain();
        end
        maybe_gap();
        send_request(action_e'($urandom_range(0, 1)), pick_key(pool_n), $urandom());
      end
    end

    wait_drain();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("PASS lru_key_value_cache");
    end else begin
      $display("FAIL lru_key_value_cache");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/lkv_pkg.sv
src/lkv_store.sv
src/lru_key_value_cache.sv
tb/testbench.sv
